@@ rtl/core/meter_scale_seven_segment_unit_macros.svh @@
`ifndef METER_SCALE_SEVEN_SEGMENT_UNIT_MACROS_SVH
`define METER_SCALE_SEVEN_SEGMENT_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define MSSU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mssu check failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define MSSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mssu check failed");

`endif

@@ rtl/core/mssu_pkg.sv @@
package mssu_pkg;

   localparam int SampleMax   = 1023;
   localparam int DigitCount  = 4;
   localparam int ShowLimit   = 9999;

   localparam int OpWidth     = 2;
   localparam int SampleWidth = 10;
   localparam int ResWidth    = 16;
   localparam int ScaleWidth  = 14;
   localparam int ShowWidth   = 14;
   localparam int SegWidth    = 7;
   localparam int CsrIdxWidth = 2;
   localparam int CsrDataWidth = 16;

   // numerator of the shared divide: widest product is resistor times sample
   localparam int NumWidth    = ResWidth + SampleWidth;
   localparam int QuotWidth   = ShowWidth;
   localparam int BcdWidth    = 4 * DigitCount;
   localparam int CountWidth  = (DigitCount > 1) ? $clog2(DigitCount) : 1;

   // quotient bits resolved per pipeline stage
   localparam int DivStepsS2  = 5;
   localparam int DivStepsS3  = 5;
   localparam int DivStepsS4  = QuotWidth - DivStepsS2 - DivStepsS3;
   // BCD conversion bits per stage
   localparam int BcdStepsS5  = ShowWidth / 2;
   localparam int BcdStepsS6  = ShowWidth - BcdStepsS5;

   localparam logic [OpWidth-1:0] OpVoltage    = 2'd0;
   localparam logic [OpWidth-1:0] OpCurrent    = 2'd1;
   localparam logic [OpWidth-1:0] OpResistance = 2'd2;
   localparam logic [OpWidth-1:0] OpOff        = 2'd3;

   localparam logic [CsrIdxWidth-1:0] CsrKnownResistance = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CsrVoltageScale    = 2'd1;
   localparam logic [CsrIdxWidth-1:0] CsrCurrentScale    = 2'd2;

   localparam logic [ResWidth-1:0]   KnownResistanceReset = 16'd1000;
   localparam logic [ScaleWidth-1:0] VoltageScaleReset    = 14'd3000;
   localparam logic [ScaleWidth-1:0] CurrentScaleReset    = 14'd5000;

   typedef struct packed {
      logic [OpWidth-1:0]     op;
      logic [SampleWidth-1:0] sample_a;
      logic [SampleWidth-1:0] sample_b;
   } req_type;

   typedef struct packed {
      logic [SegWidth-1:0]   segments;
      logic [DigitCount-1:0] digit_enable_n;
      logic [ShowWidth-1:0]  shown_value;
      logic                  over_range;
      logic                  last_digit;
   } rsp_type;

endpackage

@@ rtl/core/meter_scale_seven_segment_unit.sv @@
// Panel meter scaler with seven-segment digit output. A word is taken at a rising edge
// with start high and busy low; it holds a mode (voltage, current, resistance, off) and
// two 10-bit converter samples. Each word gives four result words, thousands digit
// first, on consecutive cycles, each flagged by rsp_strobe for exactly one cycle;
// the receiver cannot hold them off, so it must take every strobed word. The last of
// the four has last_digit set. The first digit word follows once the word has passed
// through S1 to S6 into the digit emitter at the end of the pipe, which sets the
// sustained rate and shows one digit per cycle; the six stages ahead of it take a new
// word every cycle until they fill, and busy then rises. Readings above 9999,
// and resistance with sample_a not above sample_b, show 9999 with over_range set.
// Registers are written over the csr_ port, which is always ready; write them only
// while no word is in flight.
module meter_scale_seven_segment_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  mssu_pkg::req_type                     req_data,
   output logic                                  rsp_strobe,
   output mssu_pkg::rsp_type                     rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [mssu_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [mssu_pkg::CsrDataWidth-1:0]     csr_data
);

   // One restoring-divide step: bring down the top numerator bit, subtract if it fits,
   // shift the quotient bit into the bottom of the low word.
   function automatic logic [mssu_pkg::SampleWidth+mssu_pkg::QuotWidth-1:0] div_step(
      input logic [mssu_pkg::SampleWidth-1:0] rem,
      input logic [mssu_pkg::QuotWidth-1:0]   lo,
      input logic [mssu_pkg::SampleWidth-1:0] den
   );
      logic [mssu_pkg::SampleWidth:0]   trial;
      logic [mssu_pkg::SampleWidth:0]   diff;
      logic                             fits;
      logic [mssu_pkg::SampleWidth-1:0] rem_next;
      trial    = {rem, lo[mssu_pkg::QuotWidth-1]};
      diff     = trial - {1'b0, den};
      fits     = (trial >= {1'b0, den});
      rem_next = fits ? diff[mssu_pkg::SampleWidth-1:0] : trial[mssu_pkg::SampleWidth-1:0];
      return {rem_next, lo[mssu_pkg::QuotWidth-2:0], fits};
   endfunction

   // One double-dabble step: add 3 to every nibble of 5 or more, then shift a bit in.
   function automatic logic [mssu_pkg::BcdWidth-1:0] dabble_step(
      input logic [mssu_pkg::BcdWidth-1:0] bcd,
      input logic                          bit_in
   );
      logic [mssu_pkg::BcdWidth-1:0] adj;
      adj = bcd;
      for (int n = 0; n < mssu_pkg::DigitCount; n++) begin
         if (adj[4*n +: 4] >= 4'd5) begin
            adj[4*n +: 4] = adj[4*n +: 4] + 4'd3;
         end
      end
      return {adj[mssu_pkg::BcdWidth-2:0], bit_in};
   endfunction

   function automatic logic [mssu_pkg::SegWidth-1:0] seg_lookup(input logic [3:0] digit);
      logic [mssu_pkg::SegWidth-1:0] seg;
      unique case (digit)
         4'd0:    seg = 7'h3F;
         4'd1:    seg = 7'h06;
         4'd2:    seg = 7'h5B;
         4'd3:    seg = 7'h4F;
         4'd4:    seg = 7'h66;
         4'd5:    seg = 7'h6D;
         4'd6:    seg = 7'h7D;
         4'd7:    seg = 7'h07;
         4'd8:    seg = 7'h7F;
         4'd9:    seg = 7'h6F;
         default: seg = '0;
      endcase
      return seg;
   endfunction

   localparam int SW = mssu_pkg::SampleWidth;
   localparam int QW = mssu_pkg::QuotWidth;
   localparam int NW = mssu_pkg::NumWidth;
   localparam int BW = mssu_pkg::BcdWidth;
   localparam int CW = mssu_pkg::CountWidth;

   // ---------------- configuration registers ----------------
   logic [mssu_pkg::ResWidth-1:0]   known_res_ff;
   logic [mssu_pkg::ScaleWidth-1:0] volt_scale_ff;
   logic [mssu_pkg::ScaleWidth-1:0] curr_scale_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         known_res_ff  <= mssu_pkg::KnownResistanceReset;
         volt_scale_ff <= mssu_pkg::VoltageScaleReset;
         curr_scale_ff <= mssu_pkg::CurrentScaleReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            mssu_pkg::CsrKnownResistance:
               known_res_ff  <= csr_data[mssu_pkg::ResWidth-1:0];
            mssu_pkg::CsrVoltageScale:
               volt_scale_ff <= csr_data[mssu_pkg::ScaleWidth-1:0];
            mssu_pkg::CsrCurrentScale:
               curr_scale_ff <= csr_data[mssu_pkg::ScaleWidth-1:0];
            default: ;   // unmapped index: write dropped
         endcase
      end
   end

   // ---------------- pipeline registers ----------------
   // S1: product and divisor
   logic          s1_valid_ff;
   logic [NW-1:0] s1_num_ff;
   logic [SW-1:0] s1_den_ff;
   logic          s1_over_ff;
   // S2..S4: divide, remainder plus shifting low word (numerator out, quotient in)
   logic          s2_valid_ff, s3_valid_ff, s4_valid_ff;
   logic [SW-1:0] s2_rem_ff, s3_rem_ff;
   logic [QW-1:0] s2_lo_ff, s3_lo_ff, s4_quot_ff;
   logic [SW-1:0] s2_den_ff, s3_den_ff;
   logic          s2_over_ff, s3_over_ff, s4_over_ff;
   // S5..S6: clamp and binary to BCD
   logic          s5_valid_ff, s6_valid_ff;
   logic [QW-1:0] s5_shown_ff, s6_shown_ff;
   logic [BW-1:0] s5_bcd_ff, s6_bcd_ff;
   logic          s5_over_ff, s6_over_ff;
   // digit emitter
   logic          emit_valid_ff;
   logic [CW-1:0] emit_cnt_ff;
   logic [BW-1:0] emit_bcd_ff;
   logic [QW-1:0] emit_shown_ff;
   logic          emit_over_ff;

   // ---------------- flow control ----------------
   // A stage can load when it is empty or when the stage below loads this cycle.
   logic emit_last;
   logic emit_take, s6_take, s5_take, s4_take, s3_take, s2_take, s1_take;

   assign emit_last = (emit_cnt_ff == CW'(mssu_pkg::DigitCount - 1));
   assign emit_take = !emit_valid_ff || emit_last;
   assign s6_take   = !s6_valid_ff || emit_take;
   assign s5_take   = !s5_valid_ff || s6_take;
   assign s4_take   = !s4_valid_ff || s5_take;
   assign s3_take   = !s3_valid_ff || s4_take;
   assign s2_take   = !s2_valid_ff || s3_take;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign busy      = !s1_take;

   // ---------------- S1: one 16x10 multiply, divisor select ----------------
   logic [mssu_pkg::ResWidth-1:0] mul_x;
   logic [SW-1:0]                 mul_y;
   logic [SW-1:0]                 s1_den_in;
   logic                          s1_over_in;
   logic [NW-1:0]                 s1_num_in;

   always_comb begin
      mul_x      = '0;
      mul_y      = req_data.sample_a;
      s1_den_in  = SW'(mssu_pkg::SampleMax);
      s1_over_in = 1'b0;
      unique case (req_data.op)
         mssu_pkg::OpVoltage: mul_x = mssu_pkg::ResWidth'(volt_scale_ff);
         mssu_pkg::OpCurrent: mul_x = mssu_pkg::ResWidth'(curr_scale_ff);
         mssu_pkg::OpResistance: begin
            mul_x      = known_res_ff;
            mul_y      = req_data.sample_b;
            s1_den_in  = req_data.sample_a - req_data.sample_b;
            // bridge undefined unless a > b
            s1_over_in = !(req_data.sample_a > req_data.sample_b);
         end
         mssu_pkg::OpOff: mul_x = '0;   // zero numerator reads 0
      endcase
      s1_num_in = NW'(mul_x) * NW'(mul_y);
   end

   // ---------------- S2: range check, first quotient bits ----------------
   // Quotient fits in QW bits only if the numerator's top part is below the divisor.
   logic [SW-1:0] s2_rem_in;
   logic [QW-1:0] s2_lo_in;
   logic          s2_over_in;

   always_comb begin
      s2_over_in = s1_over_ff || (s1_num_ff[NW-1:QW] >= (NW-QW)'(s1_den_ff));
      s2_rem_in  = s1_num_ff[QW +: SW];
      s2_lo_in   = s1_num_ff[QW-1:0];
      for (int i = 0; i < mssu_pkg::DivStepsS2; i++) begin
         {s2_rem_in, s2_lo_in} = div_step(s2_rem_in, s2_lo_in, s1_den_ff);
      end
   end

   // ---------------- S3, S4: remaining quotient bits ----------------
   logic [SW-1:0] s3_rem_in, s4_rem_unused;
   logic [QW-1:0] s3_lo_in, s4_quot_in;

   always_comb begin
      s3_rem_in = s2_rem_ff;
      s3_lo_in  = s2_lo_ff;
      for (int i = 0; i < mssu_pkg::DivStepsS3; i++) begin
         {s3_rem_in, s3_lo_in} = div_step(s3_rem_in, s3_lo_in, s2_den_ff);
      end
   end

   always_comb begin
      s4_rem_unused = s3_rem_ff;
      s4_quot_in    = s3_lo_ff;
      for (int i = 0; i < mssu_pkg::DivStepsS4; i++) begin
         {s4_rem_unused, s4_quot_in} = div_step(s4_rem_unused, s4_quot_in, s3_den_ff);
      end
   end

   // ---------------- S5: clamp, upper half of BCD ----------------
   logic          s5_over_in;
   logic [QW-1:0] s5_shown_in;
   logic [BW-1:0] s5_bcd_in;

   always_comb begin
      s5_over_in  = s4_over_ff || (s4_quot_ff > QW'(mssu_pkg::ShowLimit));
      s5_shown_in = s5_over_in ? QW'(mssu_pkg::ShowLimit) : s4_quot_ff;
      s5_bcd_in   = '0;
      for (int i = 0; i < mssu_pkg::BcdStepsS5; i++) begin
         s5_bcd_in = dabble_step(s5_bcd_in, s5_shown_in[QW-1-i]);
      end
   end

   // ---------------- S6: lower half of BCD ----------------
   logic [BW-1:0] s6_bcd_in;

   always_comb begin
      s6_bcd_in = s5_bcd_ff;
      for (int i = 0; i < mssu_pkg::BcdStepsS6; i++) begin
         s6_bcd_in = dabble_step(s6_bcd_in, s5_shown_ff[mssu_pkg::BcdStepsS6-1-i]);
      end
   end

   // ---------------- valid bits and emitter count ----------------
   logic [CW-1:0] emit_cnt_in;

   assign emit_cnt_in = emit_take ? '0 : CW'(emit_cnt_ff + 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         s2_valid_ff   <= 1'b0;
         s3_valid_ff   <= 1'b0;
         s4_valid_ff   <= 1'b0;
         s5_valid_ff   <= 1'b0;
         s6_valid_ff   <= 1'b0;
         emit_valid_ff <= 1'b0;
         emit_cnt_ff   <= '0;
      end else begin
         if (s1_take)   s1_valid_ff   <= start;
         if (s2_take)   s2_valid_ff   <= s1_valid_ff;
         if (s3_take)   s3_valid_ff   <= s2_valid_ff;
         if (s4_take)   s4_valid_ff   <= s3_valid_ff;
         if (s5_take)   s5_valid_ff   <= s4_valid_ff;
         if (s6_take)   s6_valid_ff   <= s5_valid_ff;
         if (emit_take) emit_valid_ff <= s6_valid_ff;
         emit_cnt_ff <= emit_cnt_in;
      end
   end

   // ---------------- payload (no reset) ----------------
   always_ff @(posedge clock) begin
      if (s1_take) begin
         s1_num_ff  <= s1_num_in;
         s1_den_ff  <= s1_den_in;
         s1_over_ff <= s1_over_in;
      end
      if (s2_take) begin
         s2_rem_ff  <= s2_rem_in;
         s2_lo_ff   <= s2_lo_in;
         s2_den_ff  <= s1_den_ff;
         s2_over_ff <= s2_over_in;
      end
      if (s3_take) begin
         s3_rem_ff  <= s3_rem_in;
         s3_lo_ff   <= s3_lo_in;
         s3_den_ff  <= s2_den_ff;
         s3_over_ff <= s2_over_ff;
      end
      if (s4_take) begin
         s4_quot_ff <= s4_quot_in;
         s4_over_ff <= s3_over_ff;
      end
      if (s5_take) begin
         s5_shown_ff <= s5_shown_in;
         s5_bcd_ff   <= s5_bcd_in;
         s5_over_ff  <= s5_over_in;
      end
      if (s6_take) begin
         s6_shown_ff <= s5_shown_ff;
         s6_bcd_ff   <= s6_bcd_in;
         s6_over_ff  <= s5_over_ff;
      end
      if (emit_take) begin
         emit_bcd_ff   <= s6_bcd_ff;
         emit_shown_ff <= s6_shown_ff;
         emit_over_ff  <= s6_over_ff;
      end
   end

   // ---------------- result word ----------------
   // digit 0 (thousands) sits in the top nibble
   logic [CW-1:0] nib_sel;
   logic [3:0]    cur_digit;

   assign nib_sel   = CW'(mssu_pkg::DigitCount - 1) - emit_cnt_ff;
   assign cur_digit = emit_bcd_ff[4*nib_sel +: 4];

   assign rsp_strobe = emit_valid_ff;

   always_comb begin
      rsp_data.segments       = seg_lookup(cur_digit);
      rsp_data.digit_enable_n = ~(mssu_pkg::DigitCount'(1) << emit_cnt_ff);
      rsp_data.shown_value    = emit_shown_ff;
      rsp_data.over_range     = emit_over_ff;
      rsp_data.last_digit     = emit_last;
   end

endmodule

@@ rtl/core/mssu_checker.sv @@
`include "meter_scale_seven_segment_unit_macros.svh"

module mssu_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_strobe,
   input mssu_pkg::rsp_type rsp_data
);

   // the digits of one reading come out on consecutive cycles
   `MSSU_ASSERT_NEXT(digits_back_to_back, clock, reset, rsp_strobe && !rsp_data.last_digit, rsp_strobe)

   // reading and flag hold across the digits of one reading
   `MSSU_ASSERT_NEXT(reading_steady, clock, reset, rsp_strobe && !rsp_data.last_digit, (rsp_data.shown_value == $past(rsp_data.shown_value)) && (rsp_data.over_range == $past(rsp_data.over_range)))

   // digit select walks one place per word
   `MSSU_ASSERT_NEXT(select_walks, clock, reset, rsp_strobe && !rsp_data.last_digit, rsp_data.digit_enable_n == (($past(rsp_data.digit_enable_n) << 1) | 4'b0001))

   // a clamped reading always shows the limit
   `MSSU_ASSERT_IMPLY(over_shows_limit, clock, reset, rsp_strobe && rsp_data.over_range, rsp_data.shown_value == mssu_pkg::ShowWidth'(mssu_pkg::ShowLimit))

endmodule

bind meter_scale_seven_segment_unit mssu_checker u_mssu_checker (.*);
